// ===== rtl/bb3_pkg.sv =====
// Shared types, codes and constants of the 3x3 grayscale box blur.
package bb3_pkg;

	// Pixel and configuration widths.
	localparam int PIX_W      = 8;
	localparam int CFG_LW_W   = 11;
	localparam int CFG_FH_W   = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 1;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [CFG_LW_W-1:0] LINE_WIDTH_RESET   = 11'd512;
	localparam logic [CFG_FH_W-1:0] FRAME_HEIGHT_RESET = 13'd512;

	// Defaults of the top-level size parameters.
	localparam int DEF_MAX_LINE_WIDTH   = 1024;
	localparam int DEF_MAX_FRAME_HEIGHT = 4096;

	// Smallest frame dimension that is used.
	localparam int MIN_SIZE = 3;

	// Codes of the action flag.
	localparam logic ACTION_PIXEL = 1'b0;
	localparam logic ACTION_FLUSH = 1'b1;

	// Count of owed outputs saturates here.
	localparam int PENDING_W = 11;
	localparam logic [PENDING_W-1:0] PENDING_MAX = 11'd2047;

	// floor(s / 9) for s up to 2295 is (s * 7282) >> 16.
	localparam int SUM_W      = 12;
	localparam int DIV9_MUL_W = 13;
	localparam int DIV9_SHIFT = 16;
	localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 13'd7282;

	// One item on its way from the accept stage to the window stage.
	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             primed;
		logic             border;
		logic             frame_end;
		logic             restart;
	} bb3_item_t;

endpackage

// ===== rtl/bb3_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bb3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Read-first behavior: a read and a write at one address return the old word.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/bb3_ctrl.sv =====
// Accept-side control: configuration, frame positions, owed count and fill count.
module bb3_ctrl #(
	parameter int MAX_LINE_WIDTH   = bb3_pkg::DEF_MAX_LINE_WIDTH,
	parameter int MAX_FRAME_HEIGHT = bb3_pkg::DEF_MAX_FRAME_HEIGHT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bb3_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bb3_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                              in_valid,
	input  logic                              in_action,
	input  logic [bb3_pkg::PIX_W-1:0]         in_pixel,
	input  logic                              slot_free,
	output logic                              in_ready,
	output logic                              load,
	output bb3_pkg::bb3_item_t                item,
	output logic [$clog2(MAX_LINE_WIDTH)-1:0] rd_col,
	output logic                              upper_we,
	output logic [$clog2(MAX_LINE_WIDTH)-1:0] upper_col
);

	import bb3_pkg::*;

	localparam int LC_W   = $clog2(MAX_LINE_WIDTH);
	localparam int LW_W   = $clog2(MAX_LINE_WIDTH + 1);
	localparam int LR_W   = $clog2(MAX_FRAME_HEIGHT);
	localparam int HW     = $clog2(MAX_FRAME_HEIGHT + 1);
	localparam int FILL_W = $clog2(MAX_LINE_WIDTH + 2);
	localparam int CWW    = (CFG_LW_W > LW_W) ? CFG_LW_W : LW_W;
	localparam int CHW    = (CFG_FH_W > HW) ? CFG_FH_W : HW;

	logic [CFG_LW_W-1:0]  line_width_q;
	logic [CFG_FH_W-1:0]  frame_height_q;
	logic [LC_W-1:0]      in_col_q;
	logic [LR_W-1:0]      in_row_q;
	logic [LC_W-1:0]      out_col_q;
	logic [LR_W-1:0]      out_row_q;
	logic [PENDING_W-1:0] pending_q;
	logic [FILL_W-1:0]    fill_q;
	logic                 upper_we_q;
	logic [LC_W-1:0]      upper_col_q;

	logic [CWW-1:0]       lw_ext;
	logic [CHW-1:0]       fh_ext;
	logic [LW_W-1:0]      w;
	logic [HW-1:0]        h;
	logic                 effective;
	logic                 primed;
	logic [LW_W-1:0]      in_col_inc;
	logic [HW-1:0]        in_row_inc;
	logic [LW_W-1:0]      out_col_inc;
	logic [HW-1:0]        out_row_inc;
	logic                 out_last_col;
	logic                 out_last_row;
	logic [LC_W-1:0]      in_col_n;
	logic [LR_W-1:0]      in_row_n;
	logic [LC_W-1:0]      out_col_n;
	logic [LR_W-1:0]      out_row_n;
	logic [PENDING_W-1:0] pending_inc;
	logic [PENDING_W-1:0] pending_n;
	logic                 restart;

	// Configuration registers, written only while the block is idle: a user rule, unchecked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= LINE_WIDTH_RESET;
			frame_height_q <= FRAME_HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LINE_WIDTH:   line_width_q   <= cfg_wdata[CFG_LW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata[CFG_FH_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the frame size to the supported range.
	always_comb begin
		lw_ext = CWW'(line_width_q);
		fh_ext = CHW'(frame_height_q);
		if (lw_ext < CWW'(MIN_SIZE)) begin
			w = LW_W'(MIN_SIZE);
		end else if (lw_ext > CWW'(MAX_LINE_WIDTH)) begin
			w = LW_W'(MAX_LINE_WIDTH);
		end else begin
			w = LW_W'(lw_ext);
		end
		if (fh_ext < CHW'(MIN_SIZE)) begin
			h = HW'(MIN_SIZE);
		end else if (fh_ext > CHW'(MAX_FRAME_HEIGHT)) begin
			h = HW'(MAX_FRAME_HEIGHT);
		end else begin
			h = HW'(fh_ext);
		end
	end

	// A flush with nothing owed is taken but has no effect.
	assign in_ready  = slot_free;
	assign effective = (in_action == ACTION_PIXEL) || (pending_q != '0);
	assign load      = in_valid && in_ready && effective;
	assign primed    = fill_q >= (FILL_W'(w) + FILL_W'(1));

	// Next input and output positions in raster order.
	always_comb begin
		in_col_inc   = LW_W'(in_col_q) + LW_W'(1);
		in_row_inc   = HW'(in_row_q) + HW'(1);
		out_col_inc  = LW_W'(out_col_q) + LW_W'(1);
		out_row_inc  = HW'(out_row_q) + HW'(1);
		out_last_col = out_col_inc >= w;
		out_last_row = out_row_inc >= h;
		if (in_col_inc >= w) begin
			in_col_n = '0;
			in_row_n = (in_row_inc >= h) ? '0 : LR_W'(in_row_inc);
		end else begin
			in_col_n = LC_W'(in_col_inc);
			in_row_n = in_row_q;
		end
		if (out_last_col) begin
			out_col_n = '0;
			out_row_n = out_last_row ? '0 : LR_W'(out_row_inc);
		end else begin
			out_col_n = LC_W'(out_col_inc);
			out_row_n = out_row_q;
		end
	end

	// Owed-output bookkeeping; a flush that settles the last owed output restarts the stream.
	always_comb begin
		pending_inc = (pending_q == PENDING_MAX) ? pending_q : pending_q + PENDING_W'(1);
		if (in_action == ACTION_PIXEL) begin
			pending_n = primed ? pending_inc - PENDING_W'(1) : pending_inc;
			restart   = 1'b0;
		end else begin
			pending_n = primed ? pending_q - PENDING_W'(1) : pending_q;
			restart   = primed && (pending_q == PENDING_W'(1));
		end
	end

	// Item handed to the window stage.
	always_comb begin
		item.pixel     = (in_action == ACTION_PIXEL) ? in_pixel : '0;
		item.primed    = primed;
		item.border    = (out_row_q == '0) || out_last_row || (out_col_q == '0) || out_last_col;
		item.frame_end = out_last_row && out_last_col;
		item.restart   = restart;
	end

	assign rd_col    = in_col_q;
	assign upper_we  = upper_we_q;
	assign upper_col = upper_col_q;

	// Stream state advances once per effective transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pending_q <= '0;
			fill_q    <= '0;
		end else if (load) begin
			if (restart) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				pending_q <= '0;
				fill_q    <= '0;
			end else begin
				in_col_q  <= in_col_n;
				in_row_q  <= in_row_n;
				pending_q <= pending_n;
				if (primed) begin
					out_col_q <= out_col_n;
					out_row_q <= out_row_n;
				end else begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
		end
	end

	// The upper row store takes the middle word in the cycle after its read.
	// A restarting item skips this write: the next stream reads that column
	// first, and such words only reach outputs of the top border row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_we_q <= 1'b0;
		end else begin
			upper_we_q <= load && !restart;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			upper_col_q <= in_col_q;
		end
	end

endmodule

// ===== rtl/bb3_window.sv =====
// Window stage: 3x3 window registers, mean by reciprocal multiply, output register.
module bb3_window (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  bb3_pkg::bb3_item_t        item,
	input  logic [bb3_pkg::PIX_W-1:0] top_rd,
	input  logic [bb3_pkg::PIX_W-1:0] mid_rd,
	output logic                      slot_free,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [bb3_pkg::PIX_W-1:0] out_pixel,
	output logic                      out_frame_end
);

	import bb3_pkg::*;

	localparam int PROD_W = SUM_W + DIV9_MUL_W;

	logic               valid_s1;
	bb3_item_t          item_s1;
	logic [PIX_W-1:0]   win_q [6];
	logic               out_valid_q;
	logic [PIX_W-1:0]   out_pixel_q;
	logic               out_frame_end_q;

	logic               out_free;
	logic               go;
	logic [SUM_W-1:0]   sum;
	logic [PROD_W-1:0]  prod;
	logic [PIX_W-1:0]   mean;
	logic [PIX_W-1:0]   result;

	// An item leaves the stage at once unless it owes an output and the output is full.
	assign out_free  = !out_valid_q || out_ready;
	assign go        = valid_s1 && (!item_s1.primed || out_free);
	assign slot_free = !valid_s1 || go;

	// Sum of the nine window pixels and floor division by nine; border items take the centre pixel instead.
	always_comb begin
		sum = SUM_W'(win_q[0]) + SUM_W'(win_q[1]) + SUM_W'(win_q[2])
		    + SUM_W'(win_q[3]) + SUM_W'(win_q[4]) + SUM_W'(win_q[5])
		    + SUM_W'(top_rd) + SUM_W'(mid_rd) + SUM_W'(item_s1.pixel);
		prod   = PROD_W'(sum) * PROD_W'(DIV9_MUL);
		mean   = prod[DIV9_SHIFT +: PIX_W];
		result = item_s1.border ? win_q[4] : mean;
	end

	// Stage register holding the item whose row store words are being read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
		end
	end

	// Window shifts by one column per item; a restart clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (go) begin
			if (item_s1.restart) begin
				for (int i = 0; i < 6; i++) begin
					win_q[i] <= '0;
				end
			end else begin
				win_q[0] <= win_q[3];
				win_q[1] <= win_q[4];
				win_q[2] <= win_q[5];
				win_q[3] <= top_rd;
				win_q[4] <= mid_rd;
				win_q[5] <= item_s1.pixel;
			end
		end
	end

	// Output register; it frees when its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && item_s1.primed) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && item_s1.primed) begin
			out_pixel_q     <= result;
			out_frame_end_q <= item_s1.frame_end;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_pixel     = out_pixel_q;
	assign out_frame_end = out_frame_end_q;

endmodule

// ===== rtl/box_blur_3x3_gray.sv =====
// Top level of the 3x3 mean box blur on an 8-bit grayscale raster stream.
//
// Channel   Direction  Payload                          Handshake
// s_axis    in         tdata: pixel_in; tuser: action   tvalid / tready
// m_axis    out        tdata: pixel_out; tlast: frame_end tvalid / tready
// cfg       in         index 0 line_width, 1 frame_height cfg_we, no wait
//
// One transfer is taken per clock while the output does not stall. An item is read
// from both row stores at its accept edge, combined in the window stage on the
// next cycle and registered at the output once the output register is free.
// The output register lets a new transfer in while a result waits.
// Reset clears positions, counts and the window; the row stores are not cleared.
// A stalled output holds the window stage, which then holds the input side.
module box_blur_3x3_gray #(
	parameter int MAX_LINE_WIDTH   = bb3_pkg::DEF_MAX_LINE_WIDTH,
	parameter int MAX_FRAME_HEIGHT = bb3_pkg::DEF_MAX_FRAME_HEIGHT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,  // [7:0] pixel_in
	input  logic                           s_axis_tuser,  // [0] action
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [7:0]                     m_axis_tdata,  // [7:0] pixel_out
	output logic                           m_axis_tlast
);

	import bb3_pkg::*;

	localparam int LC_W = $clog2(MAX_LINE_WIDTH);

	logic             load;
	logic             slot_free;
	bb3_item_t        item;
	logic [LC_W-1:0]  rd_col;
	logic             upper_we;
	logic [LC_W-1:0]  upper_col;
	logic [PIX_W-1:0] top_rd;
	logic [PIX_W-1:0] mid_rd;

	// Accept-side control.
	bb3_ctrl #(
		.MAX_LINE_WIDTH   (MAX_LINE_WIDTH),
		.MAX_FRAME_HEIGHT (MAX_FRAME_HEIGHT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_action (s_axis_tuser),
		.in_pixel  (s_axis_tdata),
		.slot_free (slot_free),
		.in_ready  (s_axis_tready),
		.load      (load),
		.item      (item),
		.rd_col    (rd_col),
		.upper_we  (upper_we),
		.upper_col (upper_col)
	);

	// Row two above the current item.
	bb3_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_LINE_WIDTH)
	) u_upper_ram (
		.clk   (clk),
		.we    (upper_we),
		.waddr (upper_col),
		.wdata (mid_rd),
		.re    (load),
		.raddr (rd_col),
		.rdata (top_rd)
	);

	// Row one above the current item.
	bb3_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_LINE_WIDTH)
	) u_middle_ram (
		.clk   (clk),
		.we    (load),
		.waddr (rd_col),
		.wdata (item.pixel),
		.re    (load),
		.raddr (rd_col),
		.rdata (mid_rd)
	);

	// Window and output stage.
	bb3_window u_window (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.item          (item),
		.top_rd        (top_rd),
		.mid_rd        (mid_rd),
		.slot_free     (slot_free),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_pixel     (m_axis_tdata),
		.out_frame_end (m_axis_tlast)
	);

	// The delayed upper-store write never lands on the column being read.
	a_upper_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(upper_we && load) |-> (upper_col != rd_col))
		else $error("upper row store write collides with a read");

	// Every upper-store write is preceded by a row store read in the cycle before.
	a_upper_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		upper_we |-> $past(load))
		else $error("upper row store write without a preceding read");

	// A new item enters the window stage only when that stage can take it.
	a_load_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> slot_free)
		else $error("item loaded while the window stage is occupied");

endmodule
